FILE: hw/rtl/midi_track_event_parser_macros.svh
// assertion helpers for the parser back end rtl
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MTEP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MTEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Types and constants shared by the track event parser front end, command
// queue and note table back end.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int NUM_KEYS     = 128;
    localparam int TICK_BITS    = 32;

    localparam int TABLE_SIZE = NUM_CHANNELS * NUM_KEYS;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int EPOCH_W    = 8;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // chunk identifier bytes
    localparam logic [7:0] TAG_0 = 8'h4D;
    localparam logic [7:0] TAG_1 = 8'h54;
    localparam logic [7:0] TAG_2 = 8'h72;
    localparam logic [7:0] TAG_3 = 8'h6B;

    // meta types
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_OTHER   = 8'h01;

    // result kinds
    localparam logic [2:0] KIND_NOTE_START = 3'd0;
    localparam logic [2:0] KIND_NOTE_END   = 3'd1;
    localparam logic [2:0] KIND_CONTROL    = 3'd2;
    localparam logic [2:0] KIND_TEMPO      = 3'd3;
    localparam logic [2:0] KIND_TIMESIG    = 3'd4;
    localparam logic [2:0] KIND_EOT        = 3'd5;
    localparam logic [2:0] KIND_BAD        = 3'd6;

    typedef logic [TICK_BITS-1:0] tick_t;

    typedef enum logic [1:0] {
        OP_EMIT     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_CLEAR    = 2'd3
    } op_code_t;

    // command from front end to back end
    typedef struct packed {
        op_code_t    code;
        logic [2:0]  kind;
        logic [3:0]  ch;
        logic [6:0]  key;
        logic [23:0] value;
        tick_t       tick;
    } op_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  chan_number;
        logic [6:0]  key_or_controller;
        logic [23:0] item_value;
        logic [31:0] event_tick;
        logic [31:0] duration_ticks;
        logic        last;
    } result_t;

    // one note table entry
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic               valid;
        tick_t              start;
    } entry_t;

    function automatic logic table_tracked(logic [3:0] ch, logic [6:0] key);
        return (32'(ch) < 32'(NUM_CHANNELS)) && (32'(key) < 32'(NUM_KEYS));
    endfunction

    function automatic logic [ADDR_W-1:0] table_addr(logic [3:0] ch, logic [6:0] key);
        return ADDR_W'(32'(ch) * 32'(NUM_KEYS) + 32'(key));
    endfunction

endpackage

FILE: hw/rtl/mtep_front.sv
// ----------------------------------------------------------------------------
// mtep_front
// Byte parser: walks the chunk header, delta times, channel and meta events
// and turns each byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module mtep_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    output logic          push,
    output mtep_pkg::op_t push_op
);
    import mtep_pkg::*;

    typedef enum logic [9:0] {
        PH_ID        = 10'b00_0000_0001,
        PH_SIZE      = 10'b00_0000_0010,
        PH_DELTA     = 10'b00_0000_0100,
        PH_STATUS    = 10'b00_0000_1000,
        PH_FIRST     = 10'b00_0001_0000,
        PH_DATA2     = 10'b00_0010_0000,
        PH_META_TYPE = 10'b00_0100_0000,
        PH_META_LEN  = 10'b00_1000_0000,
        PH_META_BODY = 10'b01_0000_0000,
        PH_BAD       = 10'b10_0000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  fidx_reg, fidx_next;
    logic [31:0] left_reg, left_next;
    tick_t       tick_reg, tick_next;
    logic [27:0] acc_reg, acc_next;
    logic [7:0]  status_reg, status_next;
    logic [6:0]  first_reg, first_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [27:0] mrem_reg, mrem_next;
    logic [23:0] payload_reg, payload_next;

    logic [7:0]  tag_byte;
    logic [27:0] acc_shift;
    logic [31:0] left_dec;
    logic [27:0] mrem_dec;
    logic [3:0]  hi;
    logic [6:0]  d2;
    logic        do_finish;
    logic [7:0]  fin_type;
    logic [23:0] fin_payload;

    // expected identifier byte
    always_comb
    begin
        case (fidx_reg)
            2'd0:    tag_byte = TAG_0;
            2'd1:    tag_byte = TAG_1;
            2'd2:    tag_byte = TAG_2;
            default: tag_byte = TAG_3;
        endcase
    end

    assign acc_shift = {acc_reg[20:0], data_byte[6:0]};
    assign left_dec  = left_reg - 32'd1;
    assign mrem_dec  = mrem_reg - 28'd1;
    assign hi        = status_reg[7:4];
    assign d2        = data_byte[6:0];

    // per-byte parse step
    always_comb
    begin
        phase_next   = phase_reg;
        fidx_next    = fidx_reg;
        left_next    = left_reg;
        tick_next    = tick_reg;
        acc_next     = acc_reg;
        status_next  = status_reg;
        first_next   = first_reg;
        mtype_next   = mtype_reg;
        mrem_next    = mrem_reg;
        payload_next = payload_reg;
        do_finish    = 1'b0;
        fin_type     = mtype_reg;
        fin_payload  = payload_reg;
        push         = 1'b0;
        push_op      = '0;
        push_op.code = OP_EMIT;
        push_op.tick = tick_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_BAD:
                begin
                end
                PH_ID:
                begin
                    if (data_byte == tag_byte)
                    begin
                        if (fidx_reg == 2'd3)
                        begin
                            fidx_next  = 2'd0;
                            left_next  = '0;
                            phase_next = PH_SIZE;
                        end
                        else
                        begin
                            fidx_next = fidx_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        push         = 1'b1;
                        push_op.kind = KIND_BAD;
                        phase_next   = PH_BAD;
                    end
                end
                PH_SIZE:
                begin
                    left_next = {left_reg[23:0], data_byte};
                    if (fidx_reg == 2'd3)
                    begin
                        fidx_next    = 2'd0;
                        tick_next    = '0;
                        status_next  = '0;
                        acc_next     = '0;
                        push         = 1'b1;
                        push_op.code = OP_CLEAR;
                        phase_next   = ({left_reg[23:0], data_byte} != 32'd0) ? PH_DELTA : PH_ID;
                    end
                    else
                    begin
                        fidx_next = fidx_reg + 2'd1;
                    end
                end
                default:
                begin
                    left_next = left_dec;
                    case (phase_reg)
                        PH_DELTA:
                        begin
                            if (data_byte[7])
                            begin
                                acc_next  = acc_shift;
                                fidx_next = 2'd1;
                            end
                            else
                            begin
                                fidx_next  = 2'd0;
                                tick_next  = tick_t'(32'(tick_reg) + 32'(acc_shift));
                                acc_next   = '0;
                                phase_next = PH_STATUS;
                            end
                        end
                        PH_STATUS:
                        begin
                            if (!data_byte[7])
                            begin
                                if (status_reg[7] && hi != 4'hF)
                                begin
                                    first_next = d2;
                                    phase_next = (hi inside {4'hC, 4'hD}) ? PH_DELTA : PH_DATA2;
                                end
                                else
                                begin
                                    phase_next = PH_DELTA;
                                end
                            end
                            else if (data_byte[7:4] != 4'hF)
                            begin
                                status_next = data_byte;
                                phase_next  = PH_FIRST;
                            end
                            else if (data_byte == 8'hFF)
                            begin
                                status_next = '0;
                                phase_next  = PH_META_TYPE;
                            end
                            else if (data_byte inside {8'hF0, 8'hF7})
                            begin
                                status_next = '0;
                                mtype_next  = META_OTHER;
                                acc_next    = '0;
                                phase_next  = PH_META_LEN;
                            end
                            else
                            begin
                                status_next = '0;
                                phase_next  = PH_DELTA;
                            end
                        end
                        PH_FIRST:
                        begin
                            first_next = d2;
                            phase_next = (hi inside {4'hC, 4'hD}) ? PH_DELTA : PH_DATA2;
                        end
                        PH_DATA2:
                        begin
                            push_op.ch    = status_reg[3:0];
                            push_op.key   = first_reg;
                            push_op.value = 24'(d2);
                            if (hi == 4'h9 && d2 != 7'd0)
                            begin
                                push         = 1'b1;
                                push_op.code = OP_NOTE_ON;
                                push_op.kind = KIND_NOTE_START;
                            end
                            else if (hi inside {4'h8, 4'h9})
                            begin
                                push         = 1'b1;
                                push_op.code = OP_NOTE_OFF;
                                push_op.kind = KIND_NOTE_END;
                            end
                            else if (hi == 4'hB)
                            begin
                                push         = 1'b1;
                                push_op.kind = KIND_CONTROL;
                            end
                            phase_next = PH_DELTA;
                        end
                        PH_META_TYPE:
                        begin
                            mtype_next = data_byte;
                            acc_next   = '0;
                            phase_next = PH_META_LEN;
                        end
                        PH_META_LEN:
                        begin
                            if (data_byte[7])
                            begin
                                acc_next  = acc_shift;
                                fidx_next = 2'd1;
                            end
                            else
                            begin
                                fidx_next    = 2'd0;
                                mrem_next    = acc_shift;
                                acc_next     = '0;
                                payload_next = '0;
                                fin_type     = mtype_reg;
                                // meta of unexpected length is skipped
                                if ((mtype_reg == META_TEMPO && acc_shift != 28'd3) ||
                                    (mtype_reg == META_TIMESIG && acc_shift != 28'd4) ||
                                    (mtype_reg == META_EOT && acc_shift != 28'd0))
                                begin
                                    fin_type = META_OTHER;
                                end
                                mtype_next  = fin_type;
                                fin_payload = '0;
                                if (acc_shift == 28'd0)
                                begin
                                    do_finish = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_META_BODY;
                                end
                            end
                        end
                        PH_META_BODY:
                        begin
                            payload_next = {payload_reg[15:0], data_byte};
                            mrem_next    = mrem_dec;
                            fin_payload  = {payload_reg[15:0], data_byte};
                            if (mrem_dec == 28'd0)
                            begin
                                do_finish = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_DELTA;
                        end
                    endcase

                    // completed meta event
                    if (do_finish)
                    begin
                        phase_next = PH_DELTA;
                        if (fin_type == META_TEMPO)
                        begin
                            push          = 1'b1;
                            push_op.kind  = KIND_TEMPO;
                            push_op.value = fin_payload;
                        end
                        else if (fin_type == META_TIMESIG)
                        begin
                            push          = 1'b1;
                            push_op.kind  = KIND_TIMESIG;
                            push_op.value = 24'(fin_payload[7:0]);
                        end
                        else if (fin_type == META_EOT)
                        begin
                            push         = 1'b1;
                            push_op.kind = KIND_EOT;
                        end
                    end

                    // chunk end, bad if an event or delta is unfinished
                    if (left_dec == 32'd0)
                    begin
                        if (phase_next != PH_DELTA || fidx_next != 2'd0)
                        begin
                            push    = 1'b1;
                            push_op = '0;
                            push_op.code = OP_EMIT;
                            push_op.kind = KIND_BAD;
                            push_op.tick = tick_next;
                        end
                        phase_next = PH_ID;
                        fidx_next  = 2'd0;
                        acc_next   = '0;
                    end
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_ID;
            fidx_reg    <= '0;
            left_reg    <= '0;
            tick_reg    <= '0;
            acc_reg     <= '0;
            status_reg  <= '0;
            first_reg   <= '0;
            mtype_reg   <= '0;
            mrem_reg    <= '0;
            payload_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fidx_reg    <= fidx_next;
            left_reg    <= left_next;
            tick_reg    <= tick_next;
            acc_reg     <= acc_next;
            status_reg  <= status_next;
            first_reg   <= first_next;
            mtype_reg   <= mtype_next;
            mrem_reg    <= mrem_next;
            payload_reg <= payload_next;
        end
    end

endmodule

FILE: hw/rtl/mtep_queue.sv
// ----------------------------------------------------------------------------
// mtep_queue
// Short command queue between the byte parser and the note table back end.
// ----------------------------------------------------------------------------
module mtep_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mtep_pkg::op_t push_op,
    input  logic          pop,
    output mtep_pkg::op_t head_op,
    output logic          not_empty,
    output logic          full
);
    import mtep_pkg::*;

    op_t                slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, wr_next;
    logic [Q_PTR_W-1:0] rd_reg, rd_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign head_op   = slot_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == Q_CNT_W'(Q_DEPTH));

    // pointer update
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_op;
        end
    end

endmodule

FILE: hw/rtl/mtep_back.sv
// ----------------------------------------------------------------------------
// mtep_back
// Executes parser commands: pairs note starts and ends through the pending
// note table and queues the results for the output channel.
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_macros.svh"

module mtep_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  mtep_pkg::op_t    q_op,
    output logic             q_pop,
    output logic             sweep_busy,
    output logic             out_valid,
    input  logic             out_stall,
    output mtep_pkg::result_t out_res
);
    import mtep_pkg::*;

    entry_t               pend_mem [TABLE_SIZE];
    entry_t               rd_data_reg;
    logic                 s2_valid_reg, s2_valid_next;
    op_t                  s2_op_reg;
    logic                 s2_fwd_reg;
    entry_t               s2_fwd_data_reg;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic                 sweep_reg, sweep_next;
    logic [ADDR_W-1:0]    sweep_addr_reg, sweep_addr_next;

    result_t              ofifo_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] owr_reg, owr_next;
    logic [OUT_PTR_W-1:0] ord_reg, ord_next;
    logic [OUT_CNT_W-1:0] ocnt_reg, ocnt_next;

    logic [ADDR_W-1:0]    head_addr;
    logic [ADDR_W-1:0]    s2_addr;
    logic                 s2_tracked;
    entry_t               entry_cur;
    logic                 hit;
    logic                 room;
    logic                 s2_done;
    logic                 wrap;
    logic                 clear_held;
    logic                 we;
    entry_t               wdata;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    entry_t               mem_wdata;
    result_t              res0, res1;
    logic [1:0]           nres;
    logic                 opop;
    logic [4:0]           chan_num;
    tick_t                dur;

    assign head_addr  = table_addr(q_op.ch, q_op.key);
    assign s2_addr    = table_addr(s2_op_reg.ch, s2_op_reg.key);
    assign s2_tracked = table_tracked(s2_op_reg.ch, s2_op_reg.key);
    assign entry_cur  = s2_fwd_reg ? s2_fwd_data_reg : rd_data_reg;
    assign hit        = s2_tracked && entry_cur.valid && (entry_cur.epoch == epoch_reg);
    assign room       = (ocnt_reg <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign s2_done    = s2_valid_reg && room;
    assign clear_held = s2_valid_reg && (s2_op_reg.code == OP_CLEAR);
    assign wrap       = s2_done && clear_held && (epoch_reg == '1);
    assign q_pop      = q_valid && !sweep_reg && !clear_held && (!s2_valid_reg || s2_done);
    assign sweep_busy = sweep_reg;
    assign chan_num   = 5'(s2_op_reg.ch) + 5'd1;
    assign dur        = s2_op_reg.tick - entry_cur.start;

    // command execution
    always_comb
    begin
        res0  = '0;
        res1  = '0;
        nres  = 2'd0;
        we    = 1'b0;
        wdata = '0;
        case (s2_op_reg.code)
            OP_EMIT:
            begin
                res0.kind       = s2_op_reg.kind;
                res0.item_value = s2_op_reg.value;
                res0.event_tick = 32'(s2_op_reg.tick);
                res0.last       = 1'b1;
                if (s2_op_reg.kind == KIND_CONTROL)
                begin
                    res0.chan_number       = chan_num;
                    res0.key_or_controller = s2_op_reg.key;
                end
                nres = 2'd1;
            end
            OP_NOTE_ON:
            begin
                wdata.epoch = epoch_reg;
                wdata.valid = 1'b1;
                wdata.start = s2_op_reg.tick;
                we          = s2_tracked;
                if (hit)
                begin
                    // retrigger closes the sounding note first
                    res0.kind              = KIND_NOTE_END;
                    res0.chan_number       = chan_num;
                    res0.key_or_controller = s2_op_reg.key;
                    res0.event_tick        = 32'(entry_cur.start);
                    res0.duration_ticks    = 32'(dur);
                    res1.kind              = KIND_NOTE_START;
                    res1.chan_number       = chan_num;
                    res1.key_or_controller = s2_op_reg.key;
                    res1.item_value        = s2_op_reg.value;
                    res1.event_tick        = 32'(s2_op_reg.tick);
                    res1.last              = 1'b1;
                    nres                   = 2'd2;
                end
                else
                begin
                    res0.kind              = KIND_NOTE_START;
                    res0.chan_number       = chan_num;
                    res0.key_or_controller = s2_op_reg.key;
                    res0.item_value        = s2_op_reg.value;
                    res0.event_tick        = 32'(s2_op_reg.tick);
                    res0.last              = 1'b1;
                    nres                   = 2'd1;
                end
            end
            OP_NOTE_OFF:
            begin
                if (hit)
                begin
                    res0.kind              = KIND_NOTE_END;
                    res0.chan_number       = chan_num;
                    res0.key_or_controller = s2_op_reg.key;
                    res0.item_value        = s2_op_reg.value;
                    res0.event_tick        = 32'(entry_cur.start);
                    res0.duration_ticks    = 32'(dur);
                    res0.last              = 1'b1;
                    nres                   = 2'd1;
                    we                     = 1'b1;
                    wdata.epoch            = epoch_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (!s2_valid_reg)
        begin
            nres = 2'd0;
            we   = 1'b0;
        end
    end

    // table write port: clearing pass or command update
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = s2_addr;
        mem_wdata = wdata;
        if (sweep_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = '0;
        end
        else if (we && s2_done)
        begin
            mem_we = 1'b1;
        end
    end

    // stage and sweep control
    always_comb
    begin
        s2_valid_next   = q_pop ? 1'b1 : (s2_done ? 1'b0 : s2_valid_reg);
        epoch_next      = (s2_done && clear_held) ? epoch_reg + 1'b1 : epoch_reg;
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        if (sweep_reg)
        begin
            sweep_addr_next = sweep_addr_reg + 1'b1;
            if (sweep_addr_reg == ADDR_W'(TABLE_SIZE - 1))
            begin
                sweep_next = 1'b0;
            end
        end
        else if (wrap)
        begin
            sweep_next      = 1'b1;
            sweep_addr_next = '0;
        end
    end

    // output queue pointers
    always_comb
    begin
        opop      = out_valid && !out_stall;
        owr_next  = (s2_done) ? owr_reg + OUT_PTR_W'(nres) : owr_reg;
        ord_next  = opop ? ord_reg + 1'b1 : ord_reg;
        ocnt_next = ocnt_reg + ((s2_done) ? OUT_CNT_W'(nres) : '0) - OUT_CNT_W'(opop);
    end

    assign out_valid = (ocnt_reg != '0);
    assign out_res   = ofifo_reg[ord_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            epoch_reg      <= '0;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            owr_reg        <= '0;
            ord_reg        <= '0;
            ocnt_reg       <= '0;
        end
        else
        begin
            s2_valid_reg   <= s2_valid_next;
            epoch_reg      <= epoch_next;
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
            owr_reg        <= owr_next;
            ord_reg        <= ord_next;
            ocnt_reg       <= ocnt_next;
        end
    end

    // stage payload, read-after-write forwarding
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_op_reg       <= q_op;
            s2_fwd_reg      <= mem_we && (mem_waddr == head_addr);
            s2_fwd_data_reg <= mem_wdata;
        end
    end

    // pending note table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pend_mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop)
        begin
            rd_data_reg <= pend_mem[head_addr];
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (s2_done && nres != 2'd0)
        begin
            ofifo_reg[owr_reg] <= res0;
        end
        if (s2_done && nres == 2'd2)
        begin
            ofifo_reg[owr_reg + 1'b1] <= res1;
        end
    end

    `MTEP_ASSERT_SAME(a_ocnt_bound, 1'b1, ocnt_reg <= OUT_CNT_W'(OUT_DEPTH), "result queue overflow")
    `MTEP_ASSERT_SAME(a_no_pop_sweep, sweep_reg, !q_pop, "command taken during clearing pass")
    `MTEP_ASSERT_SAME(a_no_pop_busy, s2_valid_reg && !s2_done, !q_pop, "command taken over busy stage")
    `MTEP_ASSERT_NEXT(a_wrap_sweep, wrap, sweep_reg && epoch_reg == '0, "epoch wrap without clearing")

endmodule

FILE: hw/rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Track chunk parser: bytes in, note, control, tempo and meta results out.
// ----------------------------------------------------------------------------
// Input channel: one track byte per transfer on data_byte (in_valid/in_stall).
// Output channel: one result per transfer (out_valid/out_stall); the final
// result caused by a byte carries last.
// Throughput: one byte per cycle while in_stall is low. A retriggered note
// start gives two results and the output drains one per cycle while
// out_stall is low, so a run of these slows intake through the command
// queue and in_stall. A byte passes the parser, command queue, note table
// read and update, and result queue.
// Reset: a clearing pass sweeps all 2048 entries of the pending note table,
// and in_stall stays high for the whole pass.
// Every 256th chunk start repeats the pass as the table epoch wraps.
// Receiver stall: results wait in a four-entry result queue; when it holds
// more than two, the back end and then the command queue hold and in_stall
// rises. Nothing is dropped.
// ----------------------------------------------------------------------------
module midi_track_event_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [4:0]  chan_number,
    output logic [6:0]  key_or_controller,
    output logic [23:0] item_value,
    output logic [31:0] event_tick,
    output logic [31:0] duration_ticks,
    output logic        last
);
    import mtep_pkg::*;

    logic    accept;
    logic    push;
    op_t     push_op;
    logic    q_pop;
    op_t     head_op;
    logic    q_not_empty;
    logic    q_full;
    logic    sweep_busy;
    result_t out_res;

    // intake gate
    assign in_stall = q_full || sweep_busy;
    assign accept   = in_valid && !in_stall;

    mtep_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .push      (push),
        .push_op   (push_op)
    );

    mtep_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (q_pop),
        .head_op   (head_op),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    mtep_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_not_empty),
        .q_op       (head_op),
        .q_pop      (q_pop),
        .sweep_busy (sweep_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (out_res)
    );

    // result fields
    assign kind              = out_res.kind;
    assign chan_number       = out_res.chan_number;
    assign key_or_controller = out_res.key_or_controller;
    assign item_value        = out_res.item_value;
    assign event_tick        = out_res.event_tick;
    assign duration_ticks    = out_res.duration_ticks;
    assign last              = out_res.last;

endmodule

FILE: tb/sv/midi_track_event_parser_tb.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser_tb
// Feeds track chunks byte by byte: a directed chunk, then random chunks of
// note, control, meta, sysex and system events, some truncated or empty,
// under several idle and stall mixes. A byte-level track decoder predicts
// every result, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module midi_track_event_parser_tb;

    import mtep_pkg::*;

    // decoder phases of the predictor
    typedef enum {
        DEC_ID, DEC_SIZE, DEC_DELTA, DEC_STATUS, DEC_DATA1, DEC_DATA2,
        DEC_META_TYPE, DEC_META_LEN, DEC_META_BODY, DEC_BAD
    } dec_phase_t;

    localparam logic [27:0] VLQ_MASK = 28'hFFF_FFFF;

    // track decoder and the queue of results it expects
    class track_scoreboard;
        result_t     expected_q[$];
        result_t     fresh_q[$];
        int          errors;
        int          checked;
        dec_phase_t  phase;
        int          field_idx;
        logic [31:0] bytes_left;
        logic [31:0] ticks;
        logic [27:0] vlq_acc;
        logic [7:0]  status;
        logic [7:0]  first_data;
        logic [7:0]  meta_type;
        logic [27:0] meta_left;
        logic [31:0] meta_data;
        bit          held[TABLE_SIZE];
        logic [31:0] held_start[TABLE_SIZE];

        function new();
            phase = DEC_ID;
            field_idx = 0;
            bytes_left = 0;
            ticks = 0;
            vlq_acc = 0;
            status = 0;
            first_data = 0;
            meta_type = 0;
            meta_left = 0;
            meta_data = 0;
            foreach (held[i]) held[i] = 0;
        endfunction

        function void add(logic [2:0] k, logic [4:0] ch, logic [6:0] key,
                          logic [23:0] val, logic [31:0] tk, logic [31:0] dur);
            result_t r;
            r.kind = k;
            r.chan_number = ch;
            r.key_or_controller = key;
            r.item_value = val;
            r.event_tick = tk;
            r.duration_ticks = dur;
            r.last = 1'b0;
            fresh_q.insert(fresh_q.size(), r);
        endfunction

        function bit take_vlq(logic [7:0] b);
            vlq_acc = ((vlq_acc << 7) | 28'(b[6:0])) & VLQ_MASK;
            field_idx = b[7] ? 1 : 0;
            return !b[7];
        endfunction

        function void take_first(logic [7:0] b);
            first_data = {1'b0, b[6:0]};
            if (status[7:4] == 4'hC || status[7:4] == 4'hD)
                phase = DEC_DELTA;
            else
                phase = DEC_DATA2;
        endfunction

        function void take_second(logic [6:0] d2);
            logic [3:0] ch;
            logic [6:0] key;
            int         idx;
            ch = status[3:0];
            key = first_data[6:0];
            idx = int'(ch) * NUM_KEYS + int'(key);
            if (status[7:4] == 4'h9 && d2 != 0) begin
                // retrigger closes the sounding note first
                if (held[idx])
                    add(KIND_NOTE_END, 5'(ch) + 5'd1, key, 0, held_start[idx],
                        ticks - held_start[idx]);
                held[idx] = 1;
                held_start[idx] = ticks;
                add(KIND_NOTE_START, 5'(ch) + 5'd1, key, 24'(d2), ticks, 0);
            end
            else if (status[7:4] == 4'h8 || status[7:4] == 4'h9) begin
                if (held[idx]) begin
                    add(KIND_NOTE_END, 5'(ch) + 5'd1, key, 24'(d2), held_start[idx],
                        ticks - held_start[idx]);
                    held[idx] = 0;
                end
            end
            else if (status[7:4] == 4'hB) begin
                add(KIND_CONTROL, 5'(ch) + 5'd1, key, 24'(d2), ticks, 0);
            end
            phase = DEC_DELTA;
        endfunction

        function void close_meta();
            if (meta_type == META_TEMPO)
                add(KIND_TEMPO, 0, 0, meta_data[23:0], ticks, 0);
            else if (meta_type == META_TIMESIG)
                add(KIND_TIMESIG, 0, 0, 24'(meta_data[7:0]), ticks, 0);
            else if (meta_type == META_EOT)
                add(KIND_EOT, 0, 0, 0, ticks, 0);
            phase = DEC_DELTA;
        endfunction

        // predict the results of one accepted byte
        function void note_byte(logic [7:0] b);
            logic [7:0] tag[4];
            tag = '{TAG_0, TAG_1, TAG_2, TAG_3};
            fresh_q.delete();
            if (phase == DEC_BAD)
                return;
            if (phase == DEC_ID) begin
                if (b == tag[field_idx % 4]) begin
                    field_idx++;
                    if (field_idx >= 4) begin
                        field_idx = 0;
                        bytes_left = 0;
                        phase = DEC_SIZE;
                    end
                end
                else begin
                    add(KIND_BAD, 0, 0, 0, ticks, 0);
                    phase = DEC_BAD;
                end
            end
            else if (phase == DEC_SIZE) begin
                bytes_left = (bytes_left << 8) | 32'(b);
                field_idx++;
                if (field_idx >= 4) begin
                    field_idx = 0;
                    ticks = 0;
                    status = 0;
                    vlq_acc = 0;
                    foreach (held[i]) held[i] = 0;
                    phase = (bytes_left != 0) ? DEC_DELTA : DEC_ID;
                end
            end
            else begin
                bytes_left--;
                case (phase)
                    DEC_DELTA:
                        if (take_vlq(b)) begin
                            ticks = ticks + 32'(vlq_acc);
                            vlq_acc = 0;
                            phase = DEC_STATUS;
                        end
                    DEC_STATUS:
                        if (b < 8'h80) begin
                            if (status >= 8'h80 && status < 8'hF0)
                                take_first(b);
                            else
                                phase = DEC_DELTA;
                        end
                        else if (b < 8'hF0) begin
                            status = b;
                            phase = DEC_DATA1;
                        end
                        else if (b == 8'hFF) begin
                            status = 0;
                            phase = DEC_META_TYPE;
                        end
                        else if (b == 8'hF0 || b == 8'hF7) begin
                            status = 0;
                            meta_type = META_OTHER;
                            vlq_acc = 0;
                            phase = DEC_META_LEN;
                        end
                        else begin
                            status = 0;
                            phase = DEC_DELTA;
                        end
                    DEC_DATA1:
                        take_first(b);
                    DEC_DATA2:
                        take_second(b[6:0]);
                    DEC_META_TYPE: begin
                        meta_type = b;
                        vlq_acc = 0;
                        phase = DEC_META_LEN;
                    end
                    DEC_META_LEN:
                        if (take_vlq(b)) begin
                            meta_left = vlq_acc;
                            vlq_acc = 0;
                            meta_data = 0;
                            // wrong length demotes the meta to a skipped one
                            if ((meta_type == META_TEMPO && meta_left != 3) ||
                                (meta_type == META_TIMESIG && meta_left != 4) ||
                                (meta_type == META_EOT && meta_left != 0))
                                meta_type = META_OTHER;
                            if (meta_left == 0)
                                close_meta();
                            else
                                phase = DEC_META_BODY;
                        end
                    DEC_META_BODY: begin
                        meta_data = (meta_data << 8) | 32'(b);
                        meta_left = meta_left - 1;
                        if (meta_left == 0)
                            close_meta();
                    end
                    default:
                        phase = DEC_DELTA;
                endcase
                // chunk end, flag an unfinished event
                if (bytes_left == 0) begin
                    if (phase != DEC_DELTA || field_idx != 0)
                        add(KIND_BAD, 0, 0, 0, ticks, 0);
                    phase = DEC_ID;
                    field_idx = 0;
                    vlq_acc = 0;
                end
            end
            if (fresh_q.size() > 0)
                fresh_q[fresh_q.size() - 1].last = 1'b1;
            foreach (fresh_q[i]) expected_q.insert(expected_q.size(), fresh_q[i]);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task compare(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // compare one result transfer against the oldest expectation
        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result kind %0d", got.kind));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare("kind", 32'(got.kind), 32'(want.kind));
            compare("chan_number", 32'(got.chan_number), 32'(want.chan_number));
            compare("key_or_controller", 32'(got.key_or_controller),
                    32'(want.key_or_controller));
            compare("item_value", 32'(got.item_value), 32'(want.item_value));
            compare("event_tick", got.event_tick, want.event_tick);
            compare("duration_ticks", got.duration_ticks, want.duration_ticks);
            compare("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [4:0]  chan_number;
    logic [6:0]  key_or_controller;
    logic [23:0] item_value;
    logic [31:0] event_tick;
    logic [31:0] duration_ticks;
    logic        last;

    track_scoreboard sb = new();
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          bytes_sent = 0;
    int          chunks_sent = 0;
    logic [7:0]  body_q[$];
    logic [7:0]  running;

    midi_track_event_parser dut (.*);

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stall
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.kind = kind;
            got.chan_number = chan_number;
            got.key_or_controller = key_or_controller;
            got.item_value = item_value;
            got.event_tick = event_tick;
            got.duration_ticks = duration_ticks;
            got.last = last;
            sb.check_result(got);
        end
    end

    // one byte transfer, with a random idle gap ahead of it
    task send_byte(logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // append one byte to the chunk body
    function void put_byte(logic [7:0] b);
        body_q.insert(body_q.size(), b);
    endfunction

    function void put_vlq(int unsigned v);
        logic [7:0] grp[$];
        do begin
            grp.push_front({(grp.size() != 0), 7'(v)});
            v = v >> 7;
        end while (v != 0);
        foreach (grp[i]) put_byte(grp[i]);
    endfunction

    function void put_delta();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            put_byte(8'h00);
        else if (r < 85)
            put_vlq($urandom_range(1, 127));
        else if (r < 97)
            put_vlq($urandom_range(128, 3000000));
        else begin
            // overlong value, only the low 28 bits count
            repeat (4) put_byte(8'h80 | 8'($urandom));
            put_byte(8'($urandom_range(127)));
        end
    endfunction

    // channel status, with running status where allowed
    function void put_channel(logic [7:0] st, int n_data, logic [6:0] d1, logic [7:0] d2);
        bit explicit;
        explicit = (st != running) || $urandom_range(1);
        if (explicit)
            put_byte(st);
        running = st;
        put_byte((explicit && $urandom_range(15) == 0) ? {1'b1, d1} : {1'b0, d1});
        if (n_data == 2)
            put_byte(d2);
    endfunction

    function void put_meta(logic [7:0] mtype, int len);
        put_byte(8'hFF);
        put_byte(mtype);
        put_vlq(len);
        repeat (len) put_byte(8'($urandom));
        running = 0;
    endfunction

    function logic [7:0] rand_data2();
        return ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(127));
    endfunction

    // one random event after its delta time
    function void put_event();
        int         r;
        logic [3:0] ch;
        logic [6:0] key;
        logic [7:0] vel;
        logic [7:0] sys[$];
        logic [7:0] sys_byte;
        r = $urandom_range(99);
        ch = ($urandom_range(9) < 8) ? 4'($urandom_range(1)) : 4'($urandom);
        key = ($urandom_range(9) < 8) ? 7'(60 + $urandom_range(3)) : 7'($urandom);
        vel = ($urandom_range(9) == 0) ? 8'h00 : rand_data2();
        if (r < 35)
            put_channel({4'h9, ch}, 2, key, vel);
        else if (r < 55)
            put_channel({4'h8, ch}, 2, key, rand_data2());
        else if (r < 65)
            put_channel({4'hB, ch}, 2, 7'($urandom), rand_data2());
        else if (r < 70)
            put_channel({$urandom_range(1) ? 4'hC : 4'hD, ch}, 1, 7'($urandom), 0);
        else if (r < 74)
            put_channel({$urandom_range(1) ? 4'hA : 4'hE, ch}, 2, key, rand_data2());
        else if (r < 78)
            put_meta(META_TEMPO, 3);
        else if (r < 81)
            put_meta(META_TIMESIG, 4);
        else if (r < 84) begin
            sys = '{META_TEMPO, META_TIMESIG, META_EOT};
            put_meta(sys[$urandom_range(2)], $urandom_range(1, 2) * 5 % 7);
        end
        else if (r < 88)
            put_meta(8'($urandom_range(127)), $urandom_range(5));
        else if (r < 91) begin
            put_byte($urandom_range(1) ? 8'hF0 : 8'hF7);
            r = $urandom_range(5);
            put_vlq(r);
            repeat (r) put_byte(8'($urandom));
            running = 0;
        end
        else if (r < 96 || running != 0) begin
            // system byte without data, never the sysex escape
            sys_byte = 8'($urandom_range(8'hF1, 8'hFE));
            if (sys_byte == 8'hF7)
                sys_byte = 8'hF8;
            put_byte(sys_byte);
            running = 0;
        end
        else
            // stray data byte with no running status
            put_byte(8'($urandom_range(127)));
    endfunction

    // identifier, size and body; size may cut the body short
    task send_chunk(int size);
        logic [7:0] tag[4];
        tag = '{TAG_0, TAG_1, TAG_2, TAG_3};
        foreach (tag[i]) send_byte(tag[i]);
        for (int i = 3; i >= 0; i--) send_byte(8'(size >> (8 * i)));
        for (int i = 0; i < size; i++) send_byte(body_q[i]);
        chunks_sent++;
    endtask

    task random_chunk();
        int size;
        body_q.delete();
        running = 0;
        repeat ($urandom_range(3, 30)) begin
            put_delta();
            put_event();
        end
        if ($urandom_range(4) != 0) begin
            put_delta();
            put_meta(META_EOT, 0);
        end
        size = body_q.size();
        if ($urandom_range(7) == 0)
            size = $urandom_range(1, size - 1);
        if ($urandom_range(19) == 0)
            size = 0;
        send_chunk(size);
    endtask

    // run limit
    initial
    begin
        #(12 * 600000);
        $display("Regression FAIL");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        int pcts[4][2];
        pcts = '{'{0, 0}, '{73, 0}, '{0, 73}, '{13, 13}};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed chunk: extremes, running status, pairing, metas, sysex
        body_q = '{8'h00, 8'h90, 8'h00, 8'h7F,
                   8'h00, 8'h7F, 8'h01,
                   8'h7F, 8'h80, 8'h00, 8'h40,
                   8'h81, 8'h00, 8'h9F, 8'hFF, 8'hFF,
                   8'h05, 8'h9F, 8'h7F, 8'h22,
                   8'h00, 8'h90, 8'h7F, 8'h00,
                   8'h00, 8'h85, 8'h10, 8'h10,
                   8'h00, 8'hBF, 8'h7F, 8'h7F,
                   8'h00, 8'hC3, 8'h05, 8'h00, 8'hD0, 8'h7F,
                   8'h00, 8'hE2, 8'h00, 8'hFF,
                   8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                   8'h00, 8'hFF, 8'h58, 8'h04, 8'h04, 8'h02, 8'h18, 8'hFF,
                   8'h00, 8'hFF, 8'h51, 8'h02, 8'h07, 8'hA1,
                   8'h00, 8'hF0, 8'h02, 8'h43, 8'hF7,
                   8'h00, 8'hF7, 8'h00, 8'h00, 8'hF8, 8'h00, 8'h55,
                   8'h8F, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h2F, 8'h00};
        send_chunk(body_q.size());
        send_chunk(0);
        send_chunk(3);

        // random chunks under each idle and stall mix
        for (int p = 0; p < 4; p++) begin
            idle_pct = pcts[p][0];
            stall_pct = pcts[p][1];
            while (bytes_sent < 100 + 470 * (p + 1))
                random_chunk();
        end

        // wrong identifier, then bytes that are ignored
        send_byte(TAG_0);
        send_byte(TAG_1);
        send_byte(8'h00);
        send_byte(8'h90);
        send_byte(8'h3C);
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d bytes in %0d chunks, checked %0d results, %0d mismatches",
                 bytes_sent, chunks_sent, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_front.sv
hw/rtl/mtep_queue.sv
hw/rtl/mtep_back.sv
hw/rtl/midi_track_event_parser.sv
tb/sv/midi_track_event_parser_tb.sv
